/* rtl/core/pngsde_pkg.sv */
// Package for the stored-deflate PNG encoder: constants and the CRC-32 byte step.
package pngsde_pkg;

    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;
    localparam int unsigned DIM_W      = 13;
    localparam int unsigned IDX_W      = 12;
    localparam int unsigned RAW_W      = 27;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [26:0] BLOCK_MAX  = 27'd65535;

    // Header byte positions
    localparam logic [5:0] HDR_IHDR_TYPE = 6'd12;
    localparam logic [5:0] HDR_IDAT_TYPE = 6'd37;
    localparam logic [5:0] HDR_LAST      = 6'd42;
    localparam logic [5:0] BLK_LAST      = 6'd4;
    localparam logic [5:0] TRL_IEND_TYPE = 6'd12;
    localparam logic [5:0] TRL_LAST      = 6'd19;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    // One byte through the reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/core/png_stored_deflate_encoder.sv */
// Streaming PNG encoder: RGBA pixels in, a complete stored-deflate PNG file out.
//
// One pixel per input transfer in raster order; one byte of the PNG file per output
// transfer. The output stage sends one byte per cycle unless m_ready holds it off; a pixel
// is 4 bytes (one more at the start of a row for the filter byte, 5 more where a stored
// block opens). The first pixel of an image also carries the 43-byte signature/IHDR/IDAT
// preamble, the last pixel the 20-byte Adler-32/CRC/IEND trailer; for a 1x1 image the
// trailer goes out on the following transfer, whose pixel is ignored. The next pixel is
// taken during the last byte of the current one. Width/height writes restart the file;
// they are taken only between pixels, and the input holds off in the cycle after a
// write while the image size settles.
module png_stored_deflate_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_run_last,
    output logic        m_image_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [pngsde_pkg::DIM_W-1:0] cfg_data
);
    import pngsde_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_HDR, ST_BLK, ST_RAW, ST_TRL} state_t;

    state_t             state_reg, state_next;
    logic [5:0]         idx_reg, idx_next;
    logic [2:0]         sub_reg, sub_next;
    logic [31:0]        pixel_reg, pixel_next;
    logic               hdr_step_reg, hdr_step_next;
    logic [31:0]        crc_reg, crc_next;
    logic [15:0]        adl_lo_reg, adl_lo_next, adl_hi_reg, adl_hi_next;
    logic [IDX_W-1:0]   col_reg, col_next, row_reg, row_next;
    logic [15:0]        blk_reg, blk_next;
    logic [RAW_W-1:0]   raw_reg, raw_next;
    logic               started_reg, started_next, pend_reg, pend_next;
    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [DIM_W-1:0]   eff_w_reg, eff_h_reg;
    logic [RAW_W-1:0]   total_reg;
    logic [11:0]        blocks_reg;
    logic [31:0]        idat_len_reg;
    logic               m_valid_reg;
    logic [7:0]         m_byte_reg;
    logic               m_run_last_reg, m_end_reg;
    logic               cfg_wait_reg;

    logic        fire, accept, done, img_end, in_crc, crc_init, cfg_hit, last_byte;
    logic [7:0]  cur_byte;
    logic [15:0] blk_n;
    logic        blk_final;
    logic [16:0] lo_sum, hi_sum;
    logic [15:0] lo_mod;
    logic [DIM_W-1:0] col_inc, row_inc;
    logic [10:0] tot_q;
    logic [16:0] tot_s, tot_rem;
    logic        tot_over;
    logic [31:0] crc_out;

    // Last byte of the current pixel, from registered state only
    assign last_byte = ((state_reg == ST_RAW) && (sub_reg == 3'd4)
                        && !((col_inc >= eff_w_reg) && (row_inc >= eff_h_reg)
                             && !hdr_step_reg))
                       || ((state_reg == ST_TRL) && (idx_reg == TRL_LAST));

    assign fire      = (state_reg != ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_ready   = ((state_reg == ST_IDLE) || (fire && last_byte))
                       && !cfg_valid && !cfg_wait_reg;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = state_reg == ST_IDLE;
    assign cfg_hit   = cfg_valid && cfg_ready
                       && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT));

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_byte_reg;
    assign m_run_last  = m_run_last_reg;
    assign m_image_end = m_end_reg;

    assign crc_out = crc_reg ^ CRC_INIT;

    // Size pipeline: clamp, raw byte count, stored block count, IDAT length
    assign tot_q    = total_reg[26:16];
    assign tot_s    = {6'd0, tot_q} + {1'b0, total_reg[15:0]};
    assign tot_over = tot_s >= 17'd65535;
    assign tot_rem  = tot_over ? tot_s - 17'd65535 : tot_s;

    always_ff @(posedge aclk) begin
        if (width_reg == '0) begin
            eff_w_reg <= DIM_W'(1);
        end else begin
            eff_w_reg <= (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
        end
        if (height_reg == '0) begin
            eff_h_reg <= DIM_W'(1);
        end else begin
            eff_h_reg <= (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;
        end
        total_reg    <= ({12'd0, eff_w_reg, 2'd0} + RAW_W'(1)) * {14'd0, eff_h_reg};
        blocks_reg   <= {1'b0, tot_q} + {11'd0, tot_over} + {11'd0, (tot_rem != '0)};
        idat_len_reg <= {5'd0, total_reg} + 32'd6 + {18'd0, blocks_reg, 2'd0}
                        + {20'd0, blocks_reg};
    end

    // Stored block header fields
    assign blk_final = raw_reg <= BLOCK_MAX;
    assign blk_n     = blk_final ? raw_reg[15:0] : 16'hFFFF;

    // Current byte select
    always_comb begin
        cur_byte = 8'h00;
        in_crc   = 1'b0;
        crc_init = 1'b0;
        case (state_reg)
            ST_HDR: begin
                in_crc   = ((idx_reg >= 6'd12) && (idx_reg <= 6'd28)) || (idx_reg >= 6'd37);
                crc_init = (idx_reg == HDR_IHDR_TYPE) || (idx_reg == HDR_IDAT_TYPE);
                case (idx_reg)
                    6'd0:  cur_byte = 8'h89;
                    6'd1:  cur_byte = 8'h50;
                    6'd2:  cur_byte = 8'h4E;
                    6'd3:  cur_byte = 8'h47;
                    6'd4:  cur_byte = 8'h0D;
                    6'd5:  cur_byte = 8'h0A;
                    6'd6:  cur_byte = 8'h1A;
                    6'd7:  cur_byte = 8'h0A;
                    6'd11: cur_byte = 8'h0D;
                    6'd12: cur_byte = 8'h49;
                    6'd13: cur_byte = 8'h48;
                    6'd14: cur_byte = 8'h44;
                    6'd15: cur_byte = 8'h52;
                    6'd18: cur_byte = {3'd0, eff_w_reg[12:8]};
                    6'd19: cur_byte = eff_w_reg[7:0];
                    6'd22: cur_byte = {3'd0, eff_h_reg[12:8]};
                    6'd23: cur_byte = eff_h_reg[7:0];
                    6'd24: cur_byte = 8'h08;
                    6'd25: cur_byte = 8'h06;
                    6'd29: cur_byte = crc_out[31:24];
                    6'd30: cur_byte = crc_out[23:16];
                    6'd31: cur_byte = crc_out[15:8];
                    6'd32: cur_byte = crc_out[7:0];
                    6'd33: cur_byte = idat_len_reg[31:24];
                    6'd34: cur_byte = idat_len_reg[23:16];
                    6'd35: cur_byte = idat_len_reg[15:8];
                    6'd36: cur_byte = idat_len_reg[7:0];
                    6'd37: cur_byte = 8'h49;
                    6'd38: cur_byte = 8'h44;
                    6'd39: cur_byte = 8'h41;
                    6'd40: cur_byte = 8'h54;
                    6'd41: cur_byte = 8'h78;
                    6'd42: cur_byte = 8'h01;
                    default: cur_byte = 8'h00;
                endcase
            end
            ST_BLK: begin
                in_crc = 1'b1;
                case (idx_reg)
                    6'd0:    cur_byte = {7'd0, blk_final};
                    6'd1:    cur_byte = blk_n[7:0];
                    6'd2:    cur_byte = blk_n[15:8];
                    6'd3:    cur_byte = ~blk_n[7:0];
                    default: cur_byte = ~blk_n[15:8];
                endcase
            end
            ST_RAW: begin
                in_crc = 1'b1;
                case (sub_reg)
                    3'd1:    cur_byte = pixel_reg[31:24];
                    3'd2:    cur_byte = pixel_reg[23:16];
                    3'd3:    cur_byte = pixel_reg[15:8];
                    3'd4:    cur_byte = pixel_reg[7:0];
                    default: cur_byte = 8'h00;
                endcase
            end
            ST_TRL: begin
                in_crc   = (idx_reg <= 6'd3) || ((idx_reg >= 6'd12) && (idx_reg <= 6'd15));
                crc_init = idx_reg == TRL_IEND_TYPE;
                case (idx_reg)
                    6'd0:  cur_byte = adl_hi_reg[15:8];
                    6'd1:  cur_byte = adl_hi_reg[7:0];
                    6'd2:  cur_byte = adl_lo_reg[15:8];
                    6'd3:  cur_byte = adl_lo_reg[7:0];
                    6'd4, 6'd16: cur_byte = crc_out[31:24];
                    6'd5, 6'd17: cur_byte = crc_out[23:16];
                    6'd6, 6'd18: cur_byte = crc_out[15:8];
                    6'd7, 6'd19: cur_byte = crc_out[7:0];
                    6'd12: cur_byte = 8'h49;
                    6'd13: cur_byte = 8'h45;
                    6'd14: cur_byte = 8'h4E;
                    6'd15: cur_byte = 8'h44;
                    default: cur_byte = 8'h00;
                endcase
            end
            default: cur_byte = 8'h00;
        endcase
    end

    // Adler-32 update for a raw byte
    assign lo_sum = {1'b0, adl_lo_reg} + {9'd0, cur_byte};
    assign lo_mod = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    assign hi_sum = {1'b0, adl_hi_reg} + {1'b0, lo_mod};

    assign col_inc = {1'b0, col_reg} + DIM_W'(1);
    assign row_inc = {1'b0, row_reg} + DIM_W'(1);

    // Sequencer next state
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        sub_next      = sub_reg;
        pixel_next    = pixel_reg;
        hdr_step_next = hdr_step_reg;
        crc_next      = crc_reg;
        adl_lo_next   = adl_lo_reg;
        adl_hi_next   = adl_hi_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        blk_next      = blk_reg;
        raw_next      = raw_reg;
        started_next  = started_reg;
        pend_next     = pend_reg;
        done          = 1'b0;
        img_end       = 1'b0;

        if (fire) begin
            if (in_crc) begin
                crc_next = crc_byte(crc_init ? CRC_INIT : crc_reg, cur_byte);
            end
            unique case (state_reg)
                ST_HDR: begin
                    if (idx_reg == '0) begin
                        raw_next     = total_reg;
                        blk_next     = '0;
                        col_next     = '0;
                        row_next     = '0;
                        adl_lo_next  = 16'd1;
                        adl_hi_next  = '0;
                        started_next = 1'b1;
                    end
                    if (idx_reg == HDR_LAST) begin
                        sub_next   = 3'd0;
                        idx_next   = '0;
                        state_next = ST_BLK;
                    end else begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
                ST_BLK: begin
                    if (idx_reg == BLK_LAST) begin
                        blk_next   = blk_n;
                        state_next = ST_RAW;
                    end else begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
                ST_RAW: begin
                    adl_lo_next = lo_mod;
                    adl_hi_next = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD)
                                                        : hi_sum[15:0];
                    if (blk_reg != '0) blk_next = blk_reg - 16'd1;
                    if (raw_reg != '0) raw_next = raw_reg - RAW_W'(1);
                    if (sub_reg == 3'd4) begin
                        if (col_inc >= eff_w_reg) begin
                            col_next = '0;
                            row_next = row_inc[IDX_W-1:0];
                            if (row_inc >= eff_h_reg) begin
                                if (hdr_step_reg) begin
                                    pend_next = 1'b1;
                                    done      = 1'b1;
                                end else begin
                                    idx_next   = '0;
                                    state_next = ST_TRL;
                                end
                            end else begin
                                done = 1'b1;
                            end
                        end else begin
                            col_next = col_inc[IDX_W-1:0];
                            done     = 1'b1;
                        end
                    end else begin
                        sub_next = sub_reg + 3'd1;
                        if (blk_next == '0) begin
                            idx_next   = '0;
                            state_next = ST_BLK;
                        end
                    end
                end
                ST_TRL: begin
                    if (idx_reg == TRL_LAST) begin
                        done         = 1'b1;
                        img_end      = 1'b1;
                        started_next = 1'b0;
                        pend_next    = 1'b0;
                    end else begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
            if (done) state_next = ST_IDLE;
        end

        // Start of a new pixel, taken from the state this cycle leaves behind
        if (accept) begin
            pixel_next    = s_pixel;
            idx_next      = '0;
            hdr_step_next = 1'b0;
            if (pend_next) begin
                state_next = ST_TRL;
            end else if (!started_next) begin
                hdr_step_next = 1'b1;
                state_next    = ST_HDR;
            end else begin
                sub_next   = (col_next == '0) ? 3'd0 : 3'd1;
                state_next = (blk_next == '0) ? ST_BLK : ST_RAW;
            end
        end

        // Register write restarts the file
        if (cfg_hit) begin
            crc_next     = CRC_INIT;
            adl_lo_next  = 16'd1;
            adl_hi_next  = '0;
            col_next     = '0;
            row_next     = '0;
            blk_next     = '0;
            raw_next     = '0;
            started_next = 1'b0;
            pend_next    = 1'b0;
        end
    end

    // State, control and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            sub_reg        <= '0;
            hdr_step_reg   <= 1'b0;
            crc_reg        <= CRC_INIT;
            adl_lo_reg     <= 16'd1;
            adl_hi_reg     <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            blk_reg        <= '0;
            raw_reg        <= '0;
            started_reg    <= 1'b0;
            pend_reg       <= 1'b0;
            width_reg      <= DIM_W'(1);
            height_reg     <= DIM_W'(1);
            m_valid_reg    <= 1'b0;
            cfg_wait_reg   <= 1'b1;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            sub_reg      <= sub_next;
            hdr_step_reg <= hdr_step_next;
            crc_reg      <= crc_next;
            adl_lo_reg   <= adl_lo_next;
            adl_hi_reg   <= adl_hi_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            blk_reg      <= blk_next;
            raw_reg      <= raw_next;
            started_reg  <= started_next;
            pend_reg     <= pend_next;
            // The size pipeline must catch up before a new image can start
            cfg_wait_reg <= cfg_hit;
            if (cfg_valid && cfg_ready && (cfg_index == CFG_WIDTH))  width_reg  <= cfg_data;
            if (cfg_valid && cfg_ready && (cfg_index == CFG_HEIGHT)) height_reg <= cfg_data;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pixel_reg <= pixel_next;
        if (fire) begin
            m_byte_reg     <= cur_byte;
            m_run_last_reg <= done;
            m_end_reg      <= img_end;
        end
    end

endmodule
